[hdl/wppm_pkg.sv]
`default_nettype none

package wppm_pkg;

  // Width of the window length register
  localparam int unsigned LEN_WIDTH = 11;
  // Width of the input sample and the emitted spread
  localparam int unsigned IN_WIDTH  = 32;
  localparam int unsigned OUT_WIDTH = 32;

  // Control shared by every cell of the ring
  typedef struct packed {
    logic advance;   // every cell takes its input word this cycle
  } cell_ctl_t;

endpackage

`default_nettype wire

[hdl/wppm_cell.sv]
`default_nettype none

module wppm_cell #(
  parameter int unsigned W = 32
) (
  input  wire logic                 clk,
  input  wire wppm_pkg::cell_ctl_t  ctl,
  input  wire logic [W-1:0]         data_in,
  output logic [W-1:0]              data_out
);

  logic [W-1:0] data;

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      data <= data_in;
    end
  end

  assign data_out = data;

endmodule

`default_nettype wire

[hdl/window_peak_to_peak_max.sv]
`default_nettype none

// Sliding-window peak-to-peak maximum. Signed samples stream in one word per
// handshake; last_sample closes a set. For every full window of window_len
// samples (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW) the block
// takes max minus min and keeps the largest; on the last sample it emits that
// value on max_spread (0 if no window filled) and starts a new set. Samples
// live in a ring of MAX_WINDOW cells. For a sample that completes a window,
// the ring rotates one full turn past a single max/min comparator at its
// tail, then the spread is folded into the running best. A new sample is
// taken only once the block is back in idle. A waiting result does not block
// the next sample; only a second result waits for it.
module window_peak_to_peak_max #(
  parameter int unsigned MAX_WINDOW   = 1024,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [wppm_pkg::IN_WIDTH-1:0] sample,
  input  wire logic                               last_sample,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [wppm_pkg::OUT_WIDTH-1:0]          max_spread,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [wppm_pkg::LEN_WIDTH-1:0]     cfg_data
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned CW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned FW = $clog2(MAX_WINDOW + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                          state;
  logic [wppm_pkg::LEN_WIDTH-1:0]      window_len;
  logic [FW-1:0]                       fill;
  logic [CW-1:0]                       cnt;
  logic [CW-1:0]                       scan_start;
  logic [SW-1:0]                       hi;
  logic [SW-1:0]                       lo;
  logic [SW-1:0]                       best;
  logic                                pend_last;

  logic                                accept;
  logic                                emit;
  logic [63:0]                         sample_ext;
  logic [SW-1:0]                       biased;
  logic [31:0]                         len32;
  logic [FW-1:0]                       eff_len;
  logic [FW-1:0]                       fill_next;
  logic                                scan_go;
  logic [SW-1:0]                       spread;
  logic [SW-1:0]                       best_next;

  wppm_pkg::cell_ctl_t                 ctl;
  logic [SW-1:0]                       head_in;
  logic [SW-1:0]                       ring [MAX_WINDOW];

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  // result goes out once the output register is free
  assign emit      = (state == ST_DONE) && pend_last && (!out_valid || out_ready);

  // Sign bit flipped so unsigned order matches signed order
  assign sample_ext = {{32{sample[wppm_pkg::IN_WIDTH-1]}}, sample};
  assign biased     = sample_ext[SW-1:0] ^ {1'b1, {(SW-1){1'b0}}};

  always_comb begin
    len32 = 32'(window_len);
    if (len32 == 32'd0) begin
      len32 = 32'd1;
    end
    if (len32 > 32'(MAX_WINDOW)) begin
      len32 = 32'(MAX_WINDOW);
    end
    eff_len = FW'(len32);
  end

  assign fill_next = (fill < FW'(MAX_WINDOW)) ? fill + FW'(1) : fill;
  assign scan_go   = (fill_next >= eff_len);
  assign spread    = hi - lo;
  assign best_next = (spread > best) ? spread : best;

  // Ring: shift a new word in on accept, rotate a full turn while scanning
  assign ctl.advance = accept || (state == ST_SCAN);
  assign head_in     = (state == ST_SCAN) ? ring[MAX_WINDOW-1] : biased;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      wppm_cell #(.W(SW)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .data_in  (head_in),
        .data_out (ring[k])
      );
    end else begin : g_body
      wppm_cell #(.W(SW)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .data_in  (ring[k-1]),
        .data_out (ring[k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= wppm_pkg::LEN_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      window_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      best      <= '0;
      pend_last <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            fill       <= fill_next;
            pend_last  <= last_sample;
            cnt        <= '0;
            scan_start <= CW'(32'(MAX_WINDOW) - len32);
            hi         <= '0;
            // no window: hi == lo leaves the best unchanged
            lo         <= scan_go ? '1 : '0;
            state      <= scan_go ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          // tail holds the word that was cnt cells from the oldest end
          if (cnt >= scan_start) begin
            if (ring[MAX_WINDOW-1] > hi) begin
              hi <= ring[MAX_WINDOW-1];
            end
            if (ring[MAX_WINDOW-1] < lo) begin
              lo <= ring[MAX_WINDOW-1];
            end
          end
          cnt <= cnt + CW'(1);
          if (cnt == CW'(MAX_WINDOW - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!pend_last) begin
            best  <= best_next;
            state <= ST_IDLE;
          end else if (emit) begin
            max_spread <= wppm_pkg::OUT_WIDTH'(best_next);
            best       <= '0;
            fill       <= '0;
            pend_last  <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
